>>> rtl/core/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types, state codes and saturation helper for the damped follower.
// ----------------------------------------------------------------------------
package cdf_pkg;

    typedef struct packed {
        logic signed [31:0] current_pos;
        logic signed [31:0] target_pos;
        logic        [30:0] elapsed;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_pos;
        logic signed [31:0] new_velocity;
        logic               snapped;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_OM_GO,
        S_OM_WAIT,
        S_MUL_X,
        S_MUL_X2,
        S_MUL_X3,
        S_MUL_T1,
        S_MUL_T2,
        S_MUL_MAXD,
        S_DEN,
        S_DEC_GO,
        S_DEC_WAIT,
        S_MUL_P,
        S_ADD_A,
        S_MUL_TMP,
        S_MUL_R,
        S_ADD_B,
        S_MUL_V,
        S_MUL_Q,
        S_RES
    } t_state;

    localparam logic [0:0] CFG_SMOOTH_TIME = 1'b0;
    localparam logic [0:0] CFG_MAX_SPEED   = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -36'sh0_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/critically_damped_follower.sv
// ----------------------------------------------------------------------------
// critically_damped_follower
// Critically damped spring step on one shared multiplier and one shared
// divider under a sequencer; velocity held between transactions.
// ----------------------------------------------------------------------------
// One transaction at a time runs through the sequencer states; the two serial
//   divisions of width DW = max(2*FRAC_BITS+2, 31) + 1 dominate. Input stalls
//   while busy and while a finished result waits for the receiver.
// Reset: synchronous, active low; velocity 0, smooth_time 1.0, max_speed max.
// ----------------------------------------------------------------------------
module critically_damped_follower #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cdf_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cdf_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [30:0]    i_cfg_data
);
    import cdf_pkg::*;

    localparam int DW = ((2 * FRAC_BITS + 2) > 31 ? (2 * FRAC_BITS + 2) : 31) + 1;
    localparam longint Q_ONE   = longint'(1) <<< FRAC_BITS;
    localparam longint MIN_SM0 = (Q_ONE + 5000) / 10000;
    localparam longint MIN_SM  = (MIN_SM0 < 1) ? 1 : MIN_SM0;
    localparam longint C048    = (48 * Q_ONE + 50) / 100;
    localparam longint C0235   = (235 * Q_ONE + 500) / 1000;
    localparam logic [DW-1:0] NUM_OM  = DW'(2) << (2 * FRAC_BITS);
    localparam logic [DW-1:0] NUM_DEC = DW'(1) << (2 * FRAC_BITS);

    t_state r_state, n_state;

    logic [30:0]        r_smooth;
    logic [30:0]        r_maxspd;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_cur, r_tgt, r_dt;
    logic signed [31:0] r_omega, r_x, r_x2, r_x3, r_t1, r_t2, r_den, r_decay;
    logic signed [31:0] r_dx, r_tmp, r_acc, r_acc2, r_vnew;
    logic               r_dpos;
    logic               r_ovalid;
    t_out               r_out;

    logic [30:0]        w_st;
    logic signed [31:0] w_ma, w_mb, w_mp;
    logic               w_dstart;
    logic [DW-1:0]      w_dnum;
    logic [30:0]        w_dden;
    logic               w_dbusy, w_ddone;
    logic signed [31:0] w_dquo;
    logic signed [32:0] w_diff;
    logic signed [31:0] w_dxs, w_dxc, w_densat, w_res;
    logic               w_accept, w_out_free, w_snap;

    assign w_st       = (r_smooth < 31'(MIN_SM)) ? 31'(MIN_SM) : r_smooth;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_diff   = 33'(r_tgt) - 33'(r_cur);
    assign w_dxs    = sat32(36'(w_diff));
    assign w_dxc    = (w_dxs > w_mp) ? w_mp : ((w_dxs < -w_mp) ? -w_mp : w_dxs);
    assign w_densat = sat32(36'(32'(Q_ONE)) + 36'(r_x) + 36'(r_t1) + 36'(r_t2));
    assign w_res    = sat32(36'(r_cur) - 36'(r_dx) + 36'(w_mp));
    assign w_snap   = (r_dpos == (w_res > r_tgt));

    cdf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_mp)
    );

    cdf_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_busy  (w_dbusy),
        .o_done  (w_ddone),
        .o_quo   (w_dquo)
    );

    always_comb begin
        n_state  = r_state;
        w_ma     = r_omega;
        w_mb     = r_dt;
        w_dstart = 1'b0;
        w_dnum   = NUM_OM + DW'(w_st >> 1);
        w_dden   = w_st;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_OM_GO;
            end
            S_OM_GO: begin
                w_dstart = 1'b1;
                n_state  = S_OM_WAIT;
            end
            S_OM_WAIT: begin
                if (w_ddone) n_state = S_MUL_X;
            end
            S_MUL_X: begin
                n_state = S_MUL_X2;
            end
            S_MUL_X2: begin
                w_ma    = w_mp;
                w_mb    = w_mp;
                n_state = S_MUL_X3;
            end
            S_MUL_X3: begin
                w_ma    = w_mp;
                w_mb    = r_x;
                n_state = S_MUL_T1;
            end
            S_MUL_T1: begin
                w_ma    = 32'(C048);
                w_mb    = r_x2;
                n_state = S_MUL_T2;
            end
            S_MUL_T2: begin
                w_ma    = 32'(C0235);
                w_mb    = r_x3;
                n_state = S_MUL_MAXD;
            end
            S_MUL_MAXD: begin
                w_ma    = $signed({1'b0, r_maxspd});
                w_mb    = $signed({1'b0, w_st});
                n_state = S_DEN;
            end
            S_DEN: begin
                n_state = S_DEC_GO;
            end
            S_DEC_GO: begin
                w_dstart = 1'b1;
                w_dnum   = NUM_DEC + DW'(r_den[30:1]);
                w_dden   = r_den[30:0];
                n_state  = S_DEC_WAIT;
            end
            S_DEC_WAIT: begin
                if (w_ddone) n_state = S_MUL_P;
            end
            S_MUL_P: begin
                w_ma    = r_omega;
                w_mb    = r_dx;
                n_state = S_ADD_A;
            end
            S_ADD_A: begin
                n_state = S_MUL_TMP;
            end
            S_MUL_TMP: begin
                w_ma    = r_acc;
                w_mb    = r_dt;
                n_state = S_MUL_R;
            end
            S_MUL_R: begin
                w_ma    = r_omega;
                w_mb    = w_mp;
                n_state = S_ADD_B;
            end
            S_ADD_B: begin
                n_state = S_MUL_V;
            end
            S_MUL_V: begin
                w_ma    = r_acc;
                w_mb    = r_decay;
                n_state = S_MUL_Q;
            end
            S_MUL_Q: begin
                w_ma    = r_acc2;
                w_mb    = r_decay;
                n_state = S_RES;
            end
            S_RES: begin
                w_ma    = r_acc2;
                w_mb    = r_decay;
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= 31'(Q_ONE);
            r_maxspd <= 31'h7FFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SMOOTH_TIME: r_smooth <= i_cfg_data;
                CFG_MAX_SPEED:   r_maxspd <= i_cfg_data;
                default:         r_smooth <= r_smooth;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_RES && w_out_free) begin
                r_ovalid <= 1'b1;
                r_vel    <= w_snap ? 32'sd0 : r_vnew;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cur <= i_in_data.current_pos;
                    r_tgt <= i_in_data.target_pos;
                    r_dt  <= $signed({1'b0, i_in_data.elapsed});
                end
            end
            S_OM_WAIT:  if (w_ddone) r_omega <= w_dquo;
            S_MUL_X2:   r_x  <= w_mp;
            S_MUL_X3:   r_x2 <= w_mp;
            S_MUL_T1:   r_x3 <= w_mp;
            S_MUL_T2:   r_t1 <= w_mp;
            S_MUL_MAXD: r_t2 <= w_mp;
            S_DEN: begin
                r_t2   <= r_t2;
                r_dx   <= w_dxc;
                r_dpos <= (w_diff > 33'sd0);
                r_den  <= (w_densat < 32'sd1) ? 32'sd1 : w_densat;
            end
            S_DEC_WAIT: if (w_ddone) r_decay <= w_dquo;
            S_ADD_A:    r_acc <= sat32(36'(r_vel) + 36'(w_mp));
            S_MUL_R:    r_tmp <= w_mp;
            S_ADD_B: begin
                r_acc  <= sat32(36'(r_vel) - 36'(w_mp));
                r_acc2 <= sat32(36'(r_dx) + 36'(r_tmp));
            end
            S_MUL_Q:    r_vnew <= w_mp;
            S_RES: begin
                if (w_out_free) begin
                    r_out.new_pos      <= w_snap ? r_tgt : w_res;
                    r_out.new_velocity <= w_snap ? 32'sd0 : r_vnew;
                    r_out.snapped      <= w_snap;
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_snap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.snapped) |-> (o_out_data.new_velocity == 32'sd0))
        else $error("snapped result with non-zero velocity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after transaction");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dstart |-> !w_dbusy)
        else $error("divider started while busy");

    a_vel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RES) |=> $stable(r_vel))
        else $error("velocity changed outside result step");

endmodule

>>> rtl/core/cdf_mul.sv
// ----------------------------------------------------------------------------
// cdf_mul
// Shared fixed-point multiplier: exact product, round half up, saturate,
// registered result.
// ----------------------------------------------------------------------------
module cdf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_p
);
    import cdf_pkg::*;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] w_prod;
    logic signed [63:0] w_rnd;
    logic signed [63:0] w_sh;
    logic signed [31:0] n_p;
    logic signed [31:0] r_p;

    assign w_prod = 64'(i_a) * 64'(i_b);
    assign w_rnd  = w_prod + HALF;
    assign w_sh   = w_rnd >>> FRAC_BITS;

    always_comb begin
        if (w_sh > 64'(S32_MAX)) begin
            n_p = S32_MAX;
        end else if (w_sh < 64'(S32_MIN)) begin
            n_p = S32_MIN;
        end else begin
            n_p = w_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/cdf_div.sv
// ----------------------------------------------------------------------------
// cdf_div
// Restoring divider, one quotient bit per cycle, quotient saturated to the
// signed 32-bit maximum.
// ----------------------------------------------------------------------------
module cdf_div #(
    parameter int DW = 35
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DW-1:0]      i_num,
    input  logic [30:0]        i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [31:0] o_quo
);
    import cdf_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_num;
    logic [30:0]   r_rem;
    logic [30:0]   r_den;
    logic [31:0]   w_trial;
    logic [31:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_num[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(DW - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[30:0] : w_trial[30:0];
            r_num <= {r_num[DW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = (|r_num[DW-1:31]) ? S32_MAX : $signed({1'b0, r_num[30:0]});

endmodule

>>> sim/critically_damped_follower_test.sv
// ----------------------------------------------------------------------------
// critically_damped_follower_test
// Drives random and directed position steps through the damped follower,
// predicts each result from a bit-exact fixed-point spring step and checks
// every output transaction in order, with random idling and a long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module critically_damped_follower_test;
    import cdf_pkg::*;

    localparam int FB = 16;
    localparam longint ONE_Q = 64'sd1 << FB;
    localparam longint HALF_Q = 64'sd1 << (FB - 1);
    localparam longint MIN_ST = (ONE_Q + 5000) / 10000;
    localparam longint K048 = (48 * ONE_Q + 50) / 100;
    localparam longint K0235 = (235 * ONE_Q + 500) / 1000;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;

    function automatic longint clip32(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip32((a * b + HALF_Q) >>> FB);
    endfunction

    class follower_scoreboard;
        longint smooth_q;
        longint speed_q;
        longint vel_q;
        t_out pending[$];
        int errors;

        function void reset_state();
            smooth_q = ONE_Q;
            speed_q = SMAX;
            vel_q = 0;
            errors = 0;
            pending.delete();
        endfunction

        task report_mismatch(string what, longint want, longint got);
            $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $realtime);
            errors++;
        endtask

        function void note_input(t_in it);
            longint cur, tgt, dt, st, om, x, x2, x3, den, dec, diff, dx, maxd;
            longint tmp, res, vel;
            bit snap;
            t_out r;
            cur = it.current_pos;
            tgt = it.target_pos;
            dt = longint'(it.elapsed);
            st = smooth_q;
            if (st < MIN_ST) st = MIN_ST;
            if (st < 1) st = 1;
            om = clip32(((64'sd2 << (2 * FB)) + st / 2) / st);
            x = qmul(om, dt);
            x2 = qmul(x, x);
            x3 = qmul(x2, x);
            den = clip32(ONE_Q + x + qmul(K048, x2) + qmul(K0235, x3));
            if (den < 1) den = 1;
            dec = clip32(((64'sd1 << (2 * FB)) + den / 2) / den);
            diff = tgt - cur;
            dx = clip32(diff);
            maxd = qmul(speed_q, st);
            if (dx > maxd) dx = maxd;
            if (dx < -maxd) dx = -maxd;
            tmp = qmul(clip32(vel_q + qmul(om, dx)), dt);
            res = clip32(cur - dx + qmul(clip32(dx + tmp), dec));
            vel = qmul(clip32(vel_q - qmul(om, tmp)), dec);
            snap = ((diff > 0) == (res > tgt));
            if (snap) begin
                res = tgt;
                vel = 0;
            end
            vel_q = vel;
            r.new_pos = res[31:0];
            r.new_velocity = vel[31:0];
            r.snapped = snap;
            pending.push_back(r);
        endfunction

        task check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 0, longint'(got.new_pos));
                return;
            end
            want = pending.pop_front();
            if (got.new_pos !== want.new_pos)
                report_mismatch("new_pos", longint'(want.new_pos), longint'(got.new_pos));
            if (got.new_velocity !== want.new_velocity)
                report_mismatch("new_velocity", longint'(want.new_velocity),
                                longint'(got.new_velocity));
            if (got.snapped !== want.snapped)
                report_mismatch("snapped", longint'(want.snapped), longint'(got.snapped));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_idx = CFG_SMOOTH_TIME;
    logic [30:0] cfg_data = '0;

    follower_scoreboard board = new();
    int quiet = 0;
    bit idling_on = 1'b1;
    bit hold_req = 1'b0;

    critically_damped_follower #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check outputs and count quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) board.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
            else quiet <= quiet + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet >= QUIET_LIMIT) begin
            $display("critically_damped_follower verification failed");
            $finish;
        end
    end

    // Receiver stall generator
    initial begin : receiver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_step(t_in it);
        int n;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.note_input(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SMOOTH_TIME) board.smooth_q = longint'(val);
        else board.speed_q = longint'(val);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_time();
        case ($urandom_range(0, 5))
            0: return 31'h7FFF_FFFF;
            1: return '0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0002_0000));
        endcase
    endfunction

    function automatic t_in step_of(logic [31:0] c, logic [31:0] t, logic [30:0] e);
        t_in it;
        it.current_pos = c;
        it.target_pos = t;
        it.elapsed = e;
        return it;
    endfunction

    task automatic random_phase(int count);
        t_in it;
        logic [31:0] p;
        p = rand_pos();
        for (int k = 0; k < count; k++) begin
            // follow a moving target most of the time so velocity builds up
            if ($urandom_range(0, 3) != 0) begin
                if (board.pending.size() == 0 && $urandom_range(0, 1))
                    p = p + $urandom_range(0, 2000) - 1000;
                it = step_of(p, rand_pos(), 31'($urandom_range(0, 32'h0000_4000)));
            end else begin
                it = step_of(rand_pos(), rand_pos(), rand_time());
            end
            send_step(it);
        end
    endtask

    initial begin : stimulus
        board.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_step(step_of(32'h0001_0000, 32'h0005_0000, 31'h0000_1000));
        send_step(step_of(32'h0001_0000, 32'h0005_0000, 31'h0000_1000));
        send_step(step_of(32'h0003_0000, 32'h0003_0000, 31'h0000_1000));
        send_step(step_of(32'h0000_0000, 32'h0002_0000, '0));
        send_step(step_of(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_8000));
        send_step(step_of(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
        send_step(step_of(32'hFFFF_0000, 32'h0000_0000, 31'h0100_0000));
        drain();
        write_reg(CFG_SMOOTH_TIME, '0);
        write_reg(CFG_MAX_SPEED, 31'h0000_0100);
        send_step(step_of(32'h0000_0000, 32'h0010_0000, 31'h0000_0100));
        send_step(step_of(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
        send_step(step_of(32'h0010_0000, 32'h0000_0000, '0));
        drain();
        write_reg(CFG_SMOOTH_TIME, 31'h7FFF_FFFF);
        write_reg(CFG_MAX_SPEED, '0);
        send_step(step_of(32'h0000_0000, 32'h0010_0000, 31'h0001_0000));
        send_step(step_of(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        drain();
        write_reg(CFG_MAX_SPEED, 31'h7FFF_FFFF);
        write_reg(CFG_SMOOTH_TIME, 31'h0000_0006);
        send_step(step_of(32'h0000_0000, 32'h0001_0000, 31'h0000_0010));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_SMOOTH_TIME, (ph == 5) ? 31'h0000_4000 :
                      31'($urandom_range(1, 32'h0004_0000)));
            write_reg(CFG_MAX_SPEED, (ph == 2) ? 31'h7FFF_FFFF :
                      31'($urandom_range(0, 32'h0100_0000)));
            if (ph == 1) hold_req = 1'b1;
            if (ph == 5) idling_on = 1'b0;
            random_phase(140);
            drain();
        end

        if (board.pending.size() == 0 && board.errors == 0) begin
            $display("critically_damped_follower verification clean");
        end else begin
            $display("critically_damped_follower verification failed");
        end
        $finish;
    end

endmodule
